// ===== src/hfct_pkg.sv =====
// Package for the hot function call counter table.
// Holds the transaction types, command and register codes, and reset constants.
// No dependencies.
`timescale 1ns / 1ps

package hfct_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned CntW            = 32;
  localparam int unsigned KeyW            = 64;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 32;

  localparam logic [1:0] CMD_CALL  = 2'd0;
  localparam logic [1:0] CMD_LOOP  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 1'b1;

  localparam logic            ENABLE_RST    = 1'b1;
  localparam logic [CntW-1:0] THRESHOLD_RST = 32'd1000;
  localparam logic [CntW-1:0] CNT_MAX       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [KeyW-1:0] function_id;
  } in_t;

  typedef struct packed {
    logic            became_hot;
    logic            tracked;
    logic [CntW-1:0] call_total;
    logic [CntW-1:0] loop_total;
    logic            marked;
  } out_t;

  typedef struct packed {
    logic            mark;
    logic [CntW-1:0] calls;
    logic [CntW-1:0] loops;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic room;
  } lookup_t;

endpackage

// ===== src/hfct_table.sv =====
// Associative entry store: valid bits, keys and counters, parallel key match.
// Depends on hfct_pkg.
`timescale 1ns / 1ps

module hfct_table #(
  parameter int unsigned TableEntries = hfct_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hfct_pkg::KeyW-1:0]     key_i,
  output hfct_pkg::lookup_t             lookup_o,
  output logic [TableEntries-1:0]       match_o,
  output logic [TableEntries-1:0]       free_low_o,
  output hfct_pkg::entry_t              entry_o,
  input  logic [TableEntries-1:0]       wr_en_i,
  input  hfct_pkg::entry_t              wr_entry_i,
  input  logic                          clear_i
);

  logic [TableEntries-1:0]   valid_q;
  logic [TableEntries-1:0]   valid_d;
  logic [hfct_pkg::KeyW-1:0] key_q [TableEntries];
  hfct_pkg::entry_t          ent_q [TableEntries];
  logic [TableEntries-1:0]   free_vec;
  hfct_pkg::entry_t          sel_entry;

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      match_o[i] = valid_q[i] && (key_q[i] == key_i);
    end
  end

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (match_o[i]) begin
        sel_entry = sel_entry | ent_q[i];
      end
    end
  end

  assign free_vec      = ~valid_q;
  assign free_low_o    = free_vec & (~free_vec + TableEntries'(1));
  assign entry_o       = sel_entry;
  assign lookup_o.hit  = |match_o;
  assign lookup_o.room = |free_vec;

  always_comb begin
    if (clear_i) begin
      valid_d = '0;
    end else begin
      valid_d = valid_q | wr_en_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TableEntries; i++) begin
      if (wr_en_i[i]) begin
        key_q[i] <= key_i;
        ent_q[i] <= wr_entry_i;
      end
    end
  end

endmodule

// ===== src/hfct_event.sv =====
// Event logic: allocation, saturating counts, hot detection and result forming.
// Depends on hfct_pkg.
`timescale 1ns / 1ps

module hfct_event #(
  parameter int unsigned TableEntries = hfct_pkg::TableEntriesDef
) (
  input  logic                          go_i,
  input  logic [1:0]                    cmd_i,
  input  logic                          enable_i,
  input  logic [hfct_pkg::CntW-1:0]     threshold_i,
  input  hfct_pkg::lookup_t             lookup_i,
  input  logic [TableEntries-1:0]       match_i,
  input  logic [TableEntries-1:0]       free_low_i,
  input  hfct_pkg::entry_t              entry_i,
  output logic [TableEntries-1:0]       wr_en_o,
  output hfct_pkg::entry_t              wr_entry_o,
  output logic                          clear_o,
  output hfct_pkg::out_t                result_o
);

  logic                      is_call;
  logic                      is_loop;
  logic                      is_clear;
  logic                      tracked;
  logic                      hot;
  logic                      do_write;
  hfct_pkg::entry_t          base;
  hfct_pkg::entry_t          upd;
  logic [hfct_pkg::CntW-1:0] next_calls;

  assign is_clear = (cmd_i == hfct_pkg::CMD_CLEAR);
  assign is_call  = enable_i && (cmd_i == hfct_pkg::CMD_CALL);
  assign is_loop  = enable_i && (cmd_i == hfct_pkg::CMD_LOOP);

  assign base    = lookup_i.hit ? entry_i : '0;
  assign tracked = !is_clear && (lookup_i.hit || (is_call && lookup_i.room));

  assign next_calls = (base.calls == hfct_pkg::CNT_MAX) ? hfct_pkg::CNT_MAX
                                                        : base.calls + 32'd1;
  assign hot = is_call && tracked && (base.calls < threshold_i)
               && (next_calls >= threshold_i);

  always_comb begin
    upd = base;
    if (is_call && tracked) begin
      upd.calls = next_calls;
      upd.mark  = base.mark | hot;
    end
    if (is_loop && lookup_i.hit && (base.loops != hfct_pkg::CNT_MAX)) begin
      upd.loops = base.loops + 32'd1;
    end
  end

  assign do_write   = go_i && ((is_call && tracked) || (is_loop && lookup_i.hit));
  assign wr_en_o    = do_write ? (lookup_i.hit ? match_i : free_low_i) : '0;
  assign wr_entry_o = upd;
  assign clear_o    = go_i && is_clear;

  always_comb begin
    result_o            = '0;
    result_o.became_hot = hot;
    result_o.tracked    = tracked;
    if (tracked) begin
      result_o.call_total = upd.calls;
      result_o.loop_total = upd.loops;
      result_o.marked     = upd.mark;
    end
  end

endmodule

// ===== src/hot_function_call_counter_table.sv =====
// Top level of the hot function call counter table.
// Depends on hfct_pkg, hfct_table and hfct_event.
//
// Takes one transaction per clock cycle while the output is not stalled; each result
// passes through the input register, then the result register, with the whole
// lookup, allocation and counter update done combinationally between them by a
// parallel key compare across all entries and one saturating increment. A stalled
// result holds in the output register while one more transaction waits in the input
// register. Configuration port writes land in registered enable and threshold settings.
`timescale 1ns / 1ps

module hot_function_call_counter_table #(
  parameter int unsigned TableEntries = hfct_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hfct_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hfct_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [hfct_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hfct_pkg::CfgDataW-1:0] cfg_data_i
);

  logic                      in_valid_q, in_valid_d;
  hfct_pkg::in_t             in_q;
  logic                      out_valid_q, out_valid_d;
  hfct_pkg::out_t            out_q;
  logic                      enable_q;
  logic [hfct_pkg::CntW-1:0] threshold_q;
  logic                      accept_in;
  logic                      advance;

  hfct_pkg::lookup_t         lookup;
  logic [TableEntries-1:0]   match;
  logic [TableEntries-1:0]   free_low;
  hfct_pkg::entry_t          entry;
  logic [TableEntries-1:0]   wr_en;
  hfct_pkg::entry_t          wr_entry;
  logic                      clear;
  hfct_pkg::out_t            result;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign accept_in   = in_valid_i && !in_stall_o;
  assign in_valid_d  = accept_in || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      enable_q    <= hfct_pkg::ENABLE_RST;
      threshold_q <= hfct_pkg::THRESHOLD_RST;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == hfct_pkg::CFG_ENABLE)) begin
        enable_q <= cfg_data_i[0];
      end
      if (cfg_we_i && (cfg_index_i == hfct_pkg::CFG_THRESHOLD)) begin
        threshold_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  hfct_table #(
    .TableEntries(TableEntries)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (in_q.function_id),
    .lookup_o   (lookup),
    .match_o    (match),
    .free_low_o (free_low),
    .entry_o    (entry),
    .wr_en_i    (wr_en),
    .wr_entry_i (wr_entry),
    .clear_i    (clear)
  );

  hfct_event #(
    .TableEntries(TableEntries)
  ) u_event (
    .go_i        (advance),
    .cmd_i       (in_q.cmd),
    .enable_i    (enable_q),
    .threshold_i (threshold_q),
    .lookup_i    (lookup),
    .match_i     (match),
    .free_low_i  (free_low),
    .entry_i     (entry),
    .wr_en_o     (wr_en),
    .wr_entry_o  (wr_entry),
    .clear_o     (clear),
    .result_o    (result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/hfct_checker.sv =====
// Port-level checker for the hot function call counter table, with its bind.
// Depends on hfct_pkg and hot_function_call_counter_table.
`timescale 1ns / 1ps

module hfct_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input hfct_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transaction dropped while stalled");

  a_hot_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.became_hot |->
      out_data_o.tracked && out_data_o.marked && (out_data_o.call_total != 32'd0))
    else $error("hot report without a marked, counted entry");

  a_untracked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.tracked |->
      (out_data_o.call_total == 32'd0) && (out_data_o.loop_total == 32'd0)
      && !out_data_o.marked && !out_data_o.became_hot)
    else $error("untracked result carries entry data");

  a_mark_has_calls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.marked |-> (out_data_o.call_total != 32'd0))
    else $error("marked entry with zero call count");

endmodule

bind hot_function_call_counter_table hfct_checker u_hfct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
